// ----- hw/rtl/spfe_pkg.sv -----
// Package for the sensor poll frame engine: codes, result type and helpers.
`default_nettype none

package spfe_pkg;

  localparam int FRAME_BYTES = 6;
  localparam int CNT_W = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1200;
  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  localparam logic [7:0] CMD_READ = 8'hA0;
  localparam logic [7:0] RESP_OK = 8'hAA;
  localparam logic [7:0] RESP_ERR = 8'hAC;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [2:0] KIND_CMD = 3'd0;
  localparam logic [2:0] KIND_READING = 3'd1;
  localparam logic [2:0] KIND_SENSOR_ERR = 3'd2;
  localparam logic [2:0] KIND_BAD_HEADER = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  localparam logic [7:0] CODE_CMD_ORDER = 8'h01;
  localparam logic [7:0] CODE_BUSY = 8'h02;
  localparam logic [7:0] CODE_CAL_FAIL = 8'h03;
  localparam logic [7:0] CODE_TEMP_RANGE = 8'h04;

  localparam logic [2:0] CLASS_CMD_ORDER = 3'd0;
  localparam logic [2:0] CLASS_BUSY = 3'd1;
  localparam logic [2:0] CLASS_CAL_FAIL = 3'd2;
  localparam logic [2:0] CLASS_TEMP_RANGE = 3'd3;
  localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

  // low byte of the sum of the first five command bytes
  localparam logic [7:0] CMD_SUM = CMD_READ;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] ion_raw;
    logic [15:0] temp_centi;
    logic        csum_match;
    logic [7:0]  sensor_code;
    logic [2:0]  error_class;
    logic [7:0]  header_byte;
    logic        last;
  } result_t;

  function automatic logic [7:0] cmd_byte(input logic [CNT_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == CNT_W'(0)) begin
      b = CMD_READ;
    end else if (idx == CNT_W'(FRAME_BYTES - 1)) begin
      b = CMD_SUM;
    end
    return b;
  endfunction

  function automatic logic [2:0] classify_code(input logic [7:0] code);
    logic [2:0] c;
    case (code)
      CODE_CMD_ORDER: c = CLASS_CMD_ORDER;
      CODE_BUSY: c = CLASS_BUSY;
      CODE_CAL_FAIL: c = CLASS_CAL_FAIL;
      CODE_TEMP_RANGE: c = CLASS_TEMP_RANGE;
      default: c = CLASS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sensor_poll_frame_engine_top.sv -----
// Sensor poll frame engine: command burst, reply gathering, frame classification, timeout.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  s        | in        | s_tvalid/s_tready | s_tuser action, s_tdata rx_byte
//  m        | out       | m_tvalid/m_tready | m_tuser result_kind, m_tdata fields, m_tlast
//  cfg      | in        | cfg_valid/ready   | cfg_data timeout_ticks
//
// One word a cycle, burst and output stalls aside: input register, one level of decode
// and update, output register. A start word yields six command words;
// the input stalls during that burst. Bytes and ticks that give no result pass even
// while the output is stalled. Synchronous reset clears control state; timeout_ticks
// returns to 1200. Frame bytes are stored only as they arrive and need no reset.
`default_nettype none

module sensor_poll_frame_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // [7:0] tx_byte, [23:8] ion_raw, [39:24] temp_centi,
                                      // [40] csum_match, [48:41] sensor_code,
                                      // [51:49] error_class, [59:52] header_byte
  output logic [2:0]       m_tuser,   // [2:0] result_kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  localparam logic [spfe_pkg::CNT_W-1:0] LAST_IDX = spfe_pkg::CNT_W'(spfe_pkg::FRAME_BYTES - 1);

  logic [15:0] timeout_ticks;

  logic       in_vld;
  logic [1:0] in_action;
  logic [7:0] in_rx;

  logic                      waiting;
  logic [spfe_pkg::CNT_W-1:0] byte_count;
  logic [7:0]                running_sum;
  logic [7:0]                frame_store [0:spfe_pkg::FRAME_BYTES-2];
  logic [15:0]               tick_count;

  logic                      waiting_next;
  logic [spfe_pkg::CNT_W-1:0] byte_count_next;
  logic [7:0]                running_sum_next;
  logic [15:0]               tick_count_next;
  logic [15:0]               tick_inc;
  logic                      store_we;
  logic                      burst_start;
  logic                      produce;
  spfe_pkg::result_t         res;
  spfe_pkg::result_t         cmd_res;

  logic                      burst;
  logic [spfe_pkg::CNT_W-1:0] burst_pos;

  logic              out_vld;
  spfe_pkg::result_t out_data;
  logic              out_free;
  logic              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= spfe_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  assign out_free = !out_vld || m_tready;
  assign advance  = in_vld && !burst && (!produce || out_free);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_rx     <= s_tdata;
    end
  end

  assign tick_inc = (tick_count != spfe_pkg::TICK_MAX) ? tick_count + 16'd1 : tick_count;

  always_comb begin
    res              = '0;
    produce          = 1'b0;
    store_we         = 1'b0;
    burst_start      = 1'b0;
    waiting_next     = waiting;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    tick_count_next  = tick_count;
    case (in_action)
      spfe_pkg::ACT_START: begin
        produce          = 1'b1;
        burst_start      = 1'b1;
        res.kind         = spfe_pkg::KIND_CMD;
        res.tx_byte      = spfe_pkg::cmd_byte('0);
        waiting_next     = 1'b1;
        byte_count_next  = '0;
        running_sum_next = '0;
        tick_count_next  = '0;
      end
      spfe_pkg::ACT_BYTE: begin
        if (waiting) begin
          if (byte_count < LAST_IDX) begin
            store_we         = 1'b1;
            running_sum_next = running_sum + in_rx;
            byte_count_next  = byte_count + spfe_pkg::CNT_W'(1);
          end else begin
            produce          = 1'b1;
            res.header_byte  = frame_store[0];
            res.last         = 1'b1;
            if (frame_store[0] == spfe_pkg::RESP_OK) begin
              res.kind        = spfe_pkg::KIND_READING;
              res.ion_raw     = {frame_store[1], frame_store[2]};
              res.temp_centi  = {frame_store[3], frame_store[4]};
              res.csum_match  = (in_rx == running_sum);
            end else if (frame_store[0] == spfe_pkg::RESP_ERR) begin
              res.kind        = spfe_pkg::KIND_SENSOR_ERR;
              res.sensor_code = frame_store[1];
              res.error_class = spfe_pkg::classify_code(frame_store[1]);
            end else begin
              res.kind        = spfe_pkg::KIND_BAD_HEADER;
            end
            waiting_next     = 1'b0;
            byte_count_next  = '0;
            running_sum_next = '0;
          end
        end
      end
      spfe_pkg::ACT_TICK: begin
        if (waiting) begin
          tick_count_next = tick_inc;
          if (tick_inc >= timeout_ticks) begin
            produce          = 1'b1;
            res.kind         = spfe_pkg::KIND_TIMEOUT;
            res.last         = 1'b1;
            waiting_next     = 1'b0;
            byte_count_next  = '0;
            running_sum_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting     <= 1'b0;
      byte_count  <= '0;
      running_sum <= '0;
      tick_count  <= '0;
    end else if (advance) begin
      waiting     <= waiting_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      tick_count  <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      frame_store[byte_count] <= in_rx;
    end
  end

  always_comb begin
    cmd_res         = '0;
    cmd_res.kind    = spfe_pkg::KIND_CMD;
    cmd_res.tx_byte = spfe_pkg::cmd_byte(burst_pos);
    cmd_res.last    = (burst_pos == LAST_IDX);
  end

  // command burst: remaining bytes after the first
  always_ff @(posedge clk) begin
    if (rst) begin
      burst     <= 1'b0;
      burst_pos <= '0;
    end else if (burst) begin
      if (out_free) begin
        if (burst_pos == LAST_IDX) begin
          burst <= 1'b0;
        end
        burst_pos <= burst_pos + spfe_pkg::CNT_W'(1);
      end
    end else if (advance && burst_start) begin
      burst     <= 1'b1;
      burst_pos <= spfe_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_free) begin
      out_vld <= burst || (advance && produce);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && burst) begin
      out_data <= cmd_res;
    end else if (out_free && advance && produce) begin
      out_data <= res;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tuser  = out_data.kind;
  assign m_tlast  = out_data.last;
  assign m_tdata  = {4'b0000, out_data.header_byte, out_data.error_class, out_data.sensor_code,
                     out_data.csum_match, out_data.temp_centi, out_data.ion_raw,
                     out_data.tx_byte};

  a_burst_has_word: assert property (@(posedge clk) disable iff (rst)
    burst |-> m_tvalid)
    else $error("command burst without a word in the output register");

  a_burst_pos_range: assert property (@(posedge clk) disable iff (rst)
    burst |-> (burst_pos != '0) && (burst_pos <= LAST_IDX))
    else $error("command burst position out of range");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_IDX)
    else $error("byte count beyond frame");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !waiting |-> (byte_count == '0) && (running_sum == '0))
    else $error("reception state left over while idle");

  a_only_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == spfe_pkg::KIND_CMD))
    else $error("non-final word that is not a command byte");

endmodule

`default_nettype wire

// ----- tb/sv/sensor_poll_frame_engine_top_tb.sv -----
// Self-checking testbench for the sensor poll frame engine: directed table, then random replies.
`timescale 1ns / 1ps

module sensor_poll_frame_engine_top_tb;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int PLAN_LEN = 27;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] data;
    logic       pinned;
    logic [2:0] kind;
    logic [7:0] head;
    logic [7:0] code;
    logic [2:0] cls;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = spfe_pkg::ACT_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  sensor_poll_frame_engine_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // mirror of the engine
  logic [15:0] p_timeout = spfe_pkg::TIMEOUT_RESET;
  bit          p_waiting = 1'b0;
  logic [2:0]  p_count = '0;
  logic [7:0]  p_sum = '0;
  logic [7:0]  p_frame [0:spfe_pkg::FRAME_BYTES-2];
  logic [15:0] p_ticks = '0;

  spfe_pkg::result_t awaited[$];
  int                fails = 0;
  int                live_items = 0;
  bit                steady = 1'b0;
  bit                pin_next = 1'b0;
  spfe_pkg::result_t pin_res;
  int                hold_cnt = 0;

  step_row_t plan [0:PLAN_LEN-1] = '{
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_TICK,  8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{ACT_SPARE,           8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_START, 8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hAA, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hA6, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_START, 8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hAA, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h12, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_START, 8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hAC, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h01, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h00, 1'b1, spfe_pkg::KIND_SENSOR_ERR, spfe_pkg::RESP_ERR,
      spfe_pkg::CODE_CMD_ORDER, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_START, 8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'h00, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b0, spfe_pkg::KIND_CMD, 8'h00, 8'h00, spfe_pkg::CLASS_CMD_ORDER},
    '{spfe_pkg::ACT_BYTE,  8'hFF, 1'b1, spfe_pkg::KIND_BAD_HEADER, 8'h00, 8'h00,
      spfe_pkg::CLASS_CMD_ORDER}
  };

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic poll_engine_step(input logic [1:0] act, input logic [7:0] b, output bit used);
    spfe_pkg::result_t r;
    logic [7:0]        cmd_sum;
    int                k;
    used = 1'b0;
    case (act)
      spfe_pkg::ACT_START: begin
        used = 1'b1;
        cmd_sum = '0;
        for (k = 0; k < spfe_pkg::FRAME_BYTES; k++) begin
          r = '0;
          r.kind = spfe_pkg::KIND_CMD;
          if (k == 0) begin
            r.tx_byte = spfe_pkg::CMD_READ;
          end else if (k == spfe_pkg::FRAME_BYTES - 1) begin
            r.tx_byte = cmd_sum;
          end
          if (k < spfe_pkg::FRAME_BYTES - 1) begin
            cmd_sum = cmd_sum + r.tx_byte;
          end
          r.last = (k == spfe_pkg::FRAME_BYTES - 1);
          awaited.push_back(r);
        end
        p_waiting = 1'b1;
        p_count = '0;
        p_sum = '0;
        p_ticks = '0;
      end
      spfe_pkg::ACT_BYTE: begin
        if (p_waiting) begin
          used = 1'b1;
          if (p_count < spfe_pkg::FRAME_BYTES - 1) begin
            p_frame[p_count] = b;
            p_sum = p_sum + b;
            p_count = p_count + 3'd1;
          end else begin
            r = '0;
            r.header_byte = p_frame[0];
            r.last = 1'b1;
            if (p_frame[0] == spfe_pkg::RESP_OK) begin
              r.kind = spfe_pkg::KIND_READING;
              r.ion_raw = {p_frame[1], p_frame[2]};
              r.temp_centi = {p_frame[3], p_frame[4]};
              r.csum_match = (b == p_sum);
            end else if (p_frame[0] == spfe_pkg::RESP_ERR) begin
              r.kind = spfe_pkg::KIND_SENSOR_ERR;
              r.sensor_code = p_frame[1];
              case (p_frame[1])
                spfe_pkg::CODE_CMD_ORDER: r.error_class = spfe_pkg::CLASS_CMD_ORDER;
                spfe_pkg::CODE_BUSY: r.error_class = spfe_pkg::CLASS_BUSY;
                spfe_pkg::CODE_CAL_FAIL: r.error_class = spfe_pkg::CLASS_CAL_FAIL;
                spfe_pkg::CODE_TEMP_RANGE: r.error_class = spfe_pkg::CLASS_TEMP_RANGE;
                default: r.error_class = spfe_pkg::CLASS_UNKNOWN;
              endcase
            end else begin
              r.kind = spfe_pkg::KIND_BAD_HEADER;
            end
            awaited.push_back(r);
            p_waiting = 1'b0;
            p_count = '0;
            p_sum = '0;
          end
        end
      end
      spfe_pkg::ACT_TICK: begin
        if (p_waiting) begin
          used = 1'b1;
          if (p_ticks != spfe_pkg::TICK_MAX) begin
            p_ticks = p_ticks + 16'd1;
          end
          if (p_ticks >= p_timeout) begin
            r = '0;
            r.kind = spfe_pkg::KIND_TIMEOUT;
            r.last = 1'b1;
            awaited.push_back(r);
            p_waiting = 1'b0;
            p_count = '0;
            p_sum = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [1:0] act, input logic [7:0] b);
    bit used;
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    poll_engine_step(act, b, used);
    if (pin_next) begin
      awaited[awaited.size() - 1] = pin_res;
      pin_next = 1'b0;
    end
    if (used) begin
      live_items++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_timeout(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_timeout = v;
  endtask

  task automatic send_reply_frame();
    logic [7:0] f [0:spfe_pkg::FRAME_BYTES-1];
    logic [7:0] s;
    int         r;
    int         k;
    r = $urandom_range(0, 99);
    f[0] = (r < 40) ? spfe_pkg::RESP_OK : (r < 70) ? spfe_pkg::RESP_ERR :
           8'($urandom_range(0, 255));
    f[1] = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
    s = f[0] + f[1];
    for (k = 2; k < spfe_pkg::FRAME_BYTES - 1; k++) begin
      f[k] = 8'($urandom_range(0, 255));
      s = s + f[k];
    end
    f[spfe_pkg::FRAME_BYTES-1] = $urandom_range(0, 1) ? s : 8'($urandom_range(0, 255));
    for (k = 0; k < spfe_pkg::FRAME_BYTES; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_word(spfe_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
      end
      push_word(spfe_pkg::ACT_BYTE, f[k]);
    end
  endtask

  // start then exactly enough ticks to expire, no gaps
  task automatic run_to_timeout();
    steady = 1'b1;
    push_word(spfe_pkg::ACT_START, 8'($urandom_range(0, 255)));
    repeat (p_timeout) push_word(spfe_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
    steady = 1'b0;
  endtask

  task automatic run_mix(input int quota);
    int first;
    int r;
    int n;
    first = live_items;
    while (live_items - first < quota) begin
      steady = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_word(spfe_pkg::ACT_START, 8'($urandom_range(0, 255)));
        send_reply_frame();
      end else if (r < 70) begin
        push_word(spfe_pkg::ACT_START, 8'($urandom_range(0, 255)));
        n = (p_timeout <= 40) ? int'(p_timeout) : $urandom_range(1, 5);
        repeat (n) push_word(spfe_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) begin
          push_word(spfe_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        end
      end else if (r < 82) begin
        push_word(spfe_pkg::ACT_START, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 5)) begin
          push_word(spfe_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        end
        push_word(spfe_pkg::ACT_START, 8'($urandom_range(0, 255)));
        send_reply_frame();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          push_word(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        end
      end
    end
    steady = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      hold_cnt <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    spfe_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited.size() == 0) begin
        $error("unexpected word: kind %0d data %0h", m_tuser, m_tdata);
        fails++;
      end else begin
        want = awaited.pop_front();
        check_field("result_kind", 64'(want.kind), 64'(m_tuser));
        check_field("tx_byte", 64'(want.tx_byte), 64'(m_tdata[7:0]));
        check_field("ion_raw", 64'(want.ion_raw), 64'(m_tdata[23:8]));
        check_field("temp_centi", 64'(want.temp_centi), 64'(m_tdata[39:24]));
        check_field("csum_match", 64'(want.csum_match), 64'(m_tdata[40]));
        check_field("sensor_code", 64'(want.sensor_code), 64'(m_tdata[48:41]));
        check_field("error_class", 64'(want.error_class), 64'(m_tdata[51:49]));
        check_field("header_byte", 64'(want.header_byte), 64'(m_tdata[59:52]));
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  initial begin : stimulus
    logic [15:0] settings [0:4];
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].pinned) begin
        pin_res = '0;
        pin_res.kind = plan[i].kind;
        pin_res.header_byte = plan[i].head;
        pin_res.sensor_code = plan[i].code;
        pin_res.error_class = plan[i].cls;
        pin_res.last = 1'b1;
        pin_next = 1'b1;
      end
      push_word(plan[i].act, plan[i].data);
    end

    run_mix(10);

    settings[0] = 16'd1;
    settings[1] = spfe_pkg::TICK_MAX;
    settings[2] = 16'd3;
    settings[3] = 16'($urandom_range(2, 12));
    settings[4] = 16'd2;
    for (i = 0; i < 5; i++) begin
      write_timeout(settings[i]);
      if (settings[i] == 16'd1) begin
        run_to_timeout();
      end
      run_mix(8);
    end

    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/spfe_pkg.sv
hw/rtl/sensor_poll_frame_engine_top.sv
tb/sv/sensor_poll_frame_engine_top_tb.sv
